// ----- design/assert_macros.svh -----
// assertion macros shared by the page tag cache index rtl
// no dependencies; checks vanish when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PTCI_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PTCI_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PTCI_ASSERT_IMP(lbl, a, b)
`define PTCI_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- design/ptci_pkg.sv -----
// shared constants, codes and types of the page tag cache index
// no dependencies
package ptci_pkg;
    localparam int PAGES_DEF       = 64;
    localparam int INDEX_SLOTS_DEF = 128;
    localparam int OFFSET_BITS_DEF = 48;

    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int PAGE_SLOT_W = 6;
    localparam int EVICT_W     = 48;
    localparam int HASH_W      = 64;

    localparam logic [HASH_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH1 = 30;
    localparam int MIX_SH2 = 27;
    localparam int MIX_SH3 = 31;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND   = 3'd0,
        STAT_CREATED = 3'd1,
        STAT_EVICTED = 3'd2,
        STAT_MISS    = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic                   done;
        status_t                status;
        logic [PAGE_SLOT_W-1:0] page_slot;
        logic [EVICT_W-1:0]     evicted;
    } result_t;
endpackage

// ----- design/ptci_front.sv -----
// front end: takes commands and hashes the tag into a home slot
// depends on ptci_pkg
module ptci_front #(
    parameter int INDEX_SLOTS = ptci_pkg::INDEX_SLOTS_DEF,
    parameter int OFFSET_BITS = ptci_pkg::OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ptci_pkg::MODE_W-1:0] mode,
    input  logic [OFFSET_BITS-1:0]      page_offset,
    output logic                        busy,
    input  logic                        q_full,
    output logic                        q_push,
    output logic [ptci_pkg::MODE_W-1:0] item_mode,
    output logic [OFFSET_BITS-1:0]      item_tag,
    output logic [$clog2(INDEX_SLOTS)-1:0] item_idx
);
    localparam int SLOT_W = $clog2(INDEX_SLOTS);
    localparam bit IS_POW2 = (INDEX_SLOTS & (INDEX_SLOTS - 1)) == 0;
    localparam int HW = ptci_pkg::HASH_W;
    // 2^32 mod slot count, used to fold the upper word onto the lower one
    localparam logic [HW-1:0] TWO_32  = HW'(1) << 32;
    localparam logic [HW-1:0] FOLD_KW = TWO_32 % HW'(INDEX_SLOTS);
    localparam logic [SLOT_W-1:0] FOLD_K = FOLD_KW[SLOT_W-1:0];
    // rounded-up reciprocal: exact quotient for any 32-bit dividend
    localparam logic [HW-1:0] RECIP_W = ((HW'(1) << (32 + SLOT_W)) + HW'(INDEX_SLOTS - 1))
                                        / HW'(INDEX_SLOTS);
    localparam logic [32:0] RECIP = RECIP_W[32:0];

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_MOD  = 4'b0100,
        F_HOLD = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic phase_reg, phase_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [ptci_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] tag_reg, tag_next;
    logic [HW-1:0] x_reg, x_next, acc_reg, acc_next, prod_reg, prod_next, h_reg, h_next;
    logic [SLOT_W-1:0] r_reg, r_next;
    logic [31:0] q_reg, q_next;

    logic [HW-1:0] t64, cst, mul_p, acc_sum, hfin;
    logic [31:0] mul_a, mul_b;
    logic [31+SLOT_W:0] fold_p;
    logic [HW-1:0] fold_sum;
    logic [64:0] recip_p, recip_q;
    logic [31:0] qm, rem32;

    assign t64 = HW'(page_offset);
    assign cst = phase_reg ? ptci_pkg::MIX_C2 : ptci_pkg::MIX_C1;
    // 64x64 low product built from three 32x32 partial products
    always_comb
    begin
        unique case (k_reg)
            2'd0:    begin mul_a = x_reg[31:0];  mul_b = cst[31:0];  end
            2'd1:    begin mul_a = x_reg[31:0];  mul_b = cst[63:32]; end
            default: begin mul_a = x_reg[63:32]; mul_b = cst[31:0];  end
        endcase
    end
    assign mul_p   = {32'b0, mul_a} * {32'b0, mul_b};
    assign acc_sum = acc_reg + {prod_reg[31:0], 32'b0};
    assign hfin    = acc_sum ^ (acc_sum >> ptci_pkg::MIX_SH3);

    // remainder for a slot count that is not a power of two:
    // three folds bring the hash below 2^32, then a reciprocal multiply
    assign fold_p   = {{SLOT_W{1'b0}}, h_reg[63:32]} * {32'b0, FOLD_K};
    assign fold_sum = HW'(fold_p) + {32'b0, h_reg[31:0]};
    assign recip_p  = {33'b0, h_reg[31:0]} * {32'b0, RECIP};
    assign recip_q  = recip_p >> (32 + SLOT_W);
    assign qm       = q_reg * 32'(INDEX_SLOTS);
    assign rem32    = h_reg[31:0] - qm;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        tag_next   = tag_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        h_next     = h_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    tag_next   = page_offset;
                    x_next     = t64 ^ (t64 >> ptci_pkg::MIX_SH1);
                    k_next     = 2'd0;
                    phase_next = 1'b0;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                k_next = k_reg + 2'd1;
                unique case (k_reg)
                    2'd0: prod_next = mul_p;
                    2'd1:
                    begin
                        acc_next  = prod_reg;
                        prod_next = mul_p;
                    end
                    2'd2:
                    begin
                        acc_next  = acc_sum;
                        prod_next = mul_p;
                    end
                    default:
                    begin
                        if (!phase_reg)
                        begin
                            x_next     = acc_sum ^ (acc_sum >> ptci_pkg::MIX_SH2);
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            h_next   = hfin;
                            cnt_next = '0;
                            if (IS_POW2)
                            begin
                                r_next     = hfin[SLOT_W-1:0];
                                state_next = F_HOLD;
                            end
                            else
                            begin
                                r_next     = '0;
                                state_next = F_MOD;
                            end
                        end
                    end
                endcase
            end
            F_MOD:
            begin
                // folds, then quotient, then remainder
                cnt_next = cnt_reg + 6'd1;
                priority if (cnt_reg < 6'd3)
                    h_next = fold_sum;
                else if (cnt_reg == 6'd3)
                    q_next = recip_q[31:0];
                else
                begin
                    r_next     = rem32[SLOT_W-1:0];
                    state_next = F_HOLD;
                end
            end
            F_HOLD:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= '0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        tag_reg  <= tag_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
    end

    assign busy      = (state_reg != F_IDLE);
    assign q_push    = (state_reg == F_HOLD) && !q_full;
    assign item_mode = mode_reg;
    assign item_tag  = tag_reg;
    assign item_idx  = r_reg;
endmodule

// ----- design/ptci_queue.sv -----
// two entry queue between the hash front end and the probe engine
// no dependencies
module ptci_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);
    logic [W-1:0] mem_reg [2];
    logic wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rd_reg];
endmodule

// ----- design/ptci_back.sv -----
// probe engine: walks the slot table, allocates pages, evicts in insertion order
// depends on ptci_pkg
module ptci_back #(
    parameter int PAGES       = ptci_pkg::PAGES_DEF,
    parameter int INDEX_SLOTS = ptci_pkg::INDEX_SLOTS_DEF,
    parameter int OFFSET_BITS = ptci_pkg::OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic [ptci_pkg::MODE_W-1:0] in_mode,
    input  logic [OFFSET_BITS-1:0]      in_tag,
    input  logic [$clog2(INDEX_SLOTS)-1:0] in_idx,
    output ptci_pkg::result_t           res
);
    localparam int SLOT_W = $clog2(INDEX_SLOTS);
    localparam int PG_W   = $clog2(PAGES);
    localparam int CNT_W  = $clog2(PAGES + 1);

    typedef enum logic [6:0] {
        B_IDLE   = 7'b0000001,
        B_READ   = 7'b0000010,
        B_CHECK  = 7'b0000100,
        B_DECIDE = 7'b0001000,
        B_VREAD  = 7'b0010000,
        B_EVICT  = 7'b0100000,
        B_INSERT = 7'b1000000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [INDEX_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [PG_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic have_reg, have_next;
    ptci_pkg::result_t res_reg, res_next;

    logic [ptci_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] tag_reg, tag_next, evict_reg, evict_next;
    logic [SLOT_W-1:0] pos_reg, pos_next, n_reg, n_next;
    logic [SLOT_W-1:0] target_reg, target_next, victim_reg, victim_next;
    logic [PG_W-1:0] page_reg, page_next;
    ptci_pkg::status_t kind_reg, kind_next;

    // slot table and age queue
    logic [OFFSET_BITS-1:0] tag_mem  [INDEX_SLOTS];
    logic [PG_W-1:0]        page_mem [INDEX_SLOTS];
    logic                   tomb_mem [INDEX_SLOTS];
    logic [SLOT_W-1:0]      age_mem  [PAGES];
    logic [OFFSET_BITS-1:0] tag_rd;
    logic [PG_W-1:0]        page_rd;
    logic                   tomb_rd;
    logic [SLOT_W-1:0]      age_rd;

    logic [SLOT_W-1:0] rd_addr, tomb_addr;
    logic ins_we, tomb_we;
    logic vld, hit;

    assign rd_addr   = (state_reg == B_VREAD) ? victim_reg : pos_reg;
    assign ins_we    = (state_reg == B_INSERT);
    assign tomb_we   = ins_we || (state_reg == B_EVICT);
    assign tomb_addr = ins_we ? target_reg : victim_reg;
    assign vld       = valid_reg[pos_reg];
    assign hit       = vld && !tomb_rd && (tag_rd == tag_reg);

    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            tag_mem[target_reg]  <= tag_reg;
            page_mem[target_reg] <= page_reg;
            age_mem[tail_reg]    <= target_reg;
        end
        if (tomb_we)
            tomb_mem[tomb_addr] <= !ins_we;
        tag_rd  <= tag_mem[rd_addr];
        page_rd <= page_mem[rd_addr];
        tomb_rd <= tomb_mem[rd_addr];
        age_rd  <= age_mem[head_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        free_next   = free_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        have_next   = have_reg;
        mode_next   = mode_reg;
        tag_next    = tag_reg;
        evict_next  = evict_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        target_next = target_reg;
        victim_next = victim_reg;
        page_next   = page_reg;
        kind_next   = kind_reg;
        res_next    = '0;
        q_pop       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    mode_next = in_mode;
                    tag_next  = in_tag;
                    pos_next  = in_idx;
                    n_next    = '0;
                    have_next = 1'b0;
                    if (in_mode == ptci_pkg::MODE_CLEAR)
                    begin
                        valid_next    = '0;
                        free_next     = '0;
                        head_next     = '0;
                        tail_next     = '0;
                        res_next.done = 1'b1;
                    end
                    else
                        state_next = B_READ;
                end
            end
            B_READ: state_next = B_CHECK;
            B_CHECK:
            begin
                if (hit)
                begin
                    res_next.done      = 1'b1;
                    res_next.status    = ptci_pkg::STAT_FOUND;
                    res_next.page_slot = ptci_pkg::PAGE_SLOT_W'(page_rd);
                    state_next         = B_IDLE;
                end
                else if (!vld)
                begin
                    if (!have_reg)
                    begin
                        target_next = pos_reg;
                        have_next   = 1'b1;
                    end
                    state_next = B_DECIDE;
                end
                else
                begin
                    if (tomb_rd && !have_reg)
                    begin
                        target_next = pos_reg;
                        have_next   = 1'b1;
                    end
                    if (n_reg == SLOT_W'(INDEX_SLOTS - 1))
                        state_next = B_DECIDE;
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        pos_next   = (pos_reg == SLOT_W'(INDEX_SLOTS - 1)) ? '0
                                                                           : pos_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            B_DECIDE:
            begin
                priority if (mode_reg != ptci_pkg::MODE_CREATE)
                begin
                    res_next.done   = 1'b1;
                    res_next.status = ptci_pkg::STAT_MISS;
                    state_next      = B_IDLE;
                end
                else if (!have_reg)
                begin
                    res_next.done   = 1'b1;
                    res_next.status = ptci_pkg::STAT_FULL;
                    state_next      = B_IDLE;
                end
                else if (free_reg < CNT_W'(PAGES))
                begin
                    page_next  = free_reg[PG_W-1:0];
                    free_next  = free_reg + 1'b1;
                    evict_next = '0;
                    kind_next  = ptci_pkg::STAT_CREATED;
                    state_next = B_INSERT;
                end
                else
                begin
                    victim_next = age_rd;
                    kind_next   = ptci_pkg::STAT_EVICTED;
                    state_next  = B_VREAD;
                end
            end
            B_VREAD: state_next = B_EVICT;
            B_EVICT:
            begin
                // victim slot turns into a tombstone, its page is reused
                page_next  = page_rd;
                evict_next = tag_rd;
                head_next  = (head_reg == PG_W'(PAGES - 1)) ? '0 : head_reg + 1'b1;
                state_next = B_INSERT;
            end
            B_INSERT:
            begin
                valid_next[target_reg] = 1'b1;
                tail_next          = (tail_reg == PG_W'(PAGES - 1)) ? '0 : tail_reg + 1'b1;
                res_next.done      = 1'b1;
                res_next.status    = kind_reg;
                res_next.page_slot = ptci_pkg::PAGE_SLOT_W'(page_reg);
                res_next.evicted   = ptci_pkg::EVICT_W'(evict_reg);
                state_next         = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= '0;
            free_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            have_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            free_reg  <= free_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            have_reg  <= have_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        tag_reg    <= tag_next;
        evict_reg  <= evict_next;
        pos_reg    <= pos_next;
        n_reg      <= n_next;
        target_reg <= target_next;
        victim_reg <= victim_next;
        page_reg   <= page_next;
        kind_reg   <= kind_next;
    end

    assign res = res_reg;
endmodule

// ----- design/page_tag_cache_index.sv -----
// a command is hashed (with a fold and reciprocal reduction when the slot count is not a
// power of two) and queued; the probe engine then reads and checks slots in turn until a hit,
// an empty slot or a full wrap; a create uses a free page or first evicts the oldest page
// the front end takes the next command once it has pushed the last one into the
// two-entry queue and stalls while that queue is full; results are one-cycle done strobes
// reset: rst_n async low clears all slots to empty, the page counter and the age queue
`include "assert_macros.svh"
module page_tag_cache_index #(
    parameter int PAGES       = ptci_pkg::PAGES_DEF,
    parameter int INDEX_SLOTS = ptci_pkg::INDEX_SLOTS_DEF,
    parameter int OFFSET_BITS = ptci_pkg::OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ptci_pkg::MODE_W-1:0]      mode,
    input  logic [OFFSET_BITS-1:0]           page_offset,
    output logic                             done,
    output logic [ptci_pkg::STATUS_W-1:0]    status,
    output logic [ptci_pkg::PAGE_SLOT_W-1:0] page_slot,
    output logic [ptci_pkg::EVICT_W-1:0]     evicted_offset
);
    localparam int SLOT_W = $clog2(INDEX_SLOTS);
    localparam int IW     = ptci_pkg::MODE_W + OFFSET_BITS + SLOT_W;

    // front to queue transfer
    logic q_push, q_full, q_pop, q_empty;
    logic [ptci_pkg::MODE_W-1:0] f_mode, b_mode;
    logic [OFFSET_BITS-1:0] f_tag, b_tag;
    logic [SLOT_W-1:0] f_idx, b_idx;
    logic [IW-1:0] q_wdata, q_rdata;
    ptci_pkg::result_t res;
    logic res_not_evict, res_no_page;

    // hash unit: splitmix finalizer then reduction to a home slot
    ptci_front #(
        .INDEX_SLOTS(INDEX_SLOTS),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .page_offset(page_offset),
        .busy       (busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .item_mode  (f_mode),
        .item_tag   (f_tag),
        .item_idx   (f_idx)
    );

    assign q_wdata = {f_mode, f_tag, f_idx};

    // decouples hashing from probing
    ptci_queue #(
        .W(IW)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(q_wdata),
        .full (q_full),
        .pop  (q_pop),
        .empty(q_empty),
        .rdata(q_rdata)
    );

    assign {b_mode, b_tag, b_idx} = q_rdata;

    // probe engine with slot table and fifo replacement
    ptci_back #(
        .PAGES      (PAGES),
        .INDEX_SLOTS(INDEX_SLOTS),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .q_pop  (q_pop),
        .in_mode(b_mode),
        .in_tag (b_tag),
        .in_idx (b_idx),
        .res    (res)
    );

    // result transfer straight from the back end's output register
    assign done           = res.done;
    assign status         = res.status;
    assign page_slot      = res.page_slot;
    assign evicted_offset = res.evicted;

    // result kinds that carry no evicted tag or no page
    assign res_not_evict = done && (status != ptci_pkg::STAT_EVICTED);
    assign res_no_page   = done && (status == ptci_pkg::STAT_MISS ||
                                    status == ptci_pkg::STAT_FULL);

    `PTCI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PTCI_ASSERT_IMP(a_evict_only, res_not_evict, evicted_offset == '0)
    `PTCI_ASSERT_IMP(a_miss_no_page, res_no_page, page_slot == '0)
    `PTCI_ASSERT_IMP(a_pop_valid, q_pop, !q_empty)
endmodule
